/* design/gbc_pkg.sv */
// Package: shared constants, stage type and substitution function of the cipher.
`default_nettype none
package gbc_pkg;

  localparam int unsigned ROUNDS_DEF = 32;
  localparam int unsigned KEY_WORDS  = 8;
  localparam int unsigned KEY_IDX_W  = 3;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ROT_BITS   = 11;

  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
  } stage_t;

  typedef logic [3:0] nibble_t;

  localparam nibble_t SBOX [8][16] = '{
    '{4'd3,  4'd5,  4'd7,  4'd9,  4'd0,  4'd8,  4'd6,  4'd4,
      4'd2,  4'd1,  4'd15, 4'd10, 4'd12, 4'd14, 4'd13, 4'd11},
    '{4'd1,  4'd3,  4'd5,  4'd7,  4'd9,  4'd11, 4'd13, 4'd15,
      4'd14, 4'd12, 4'd10, 4'd8,  4'd6,  4'd4,  4'd2,  4'd0},
    '{4'd15, 4'd13, 4'd11, 4'd9,  4'd7,  4'd5,  4'd3,  4'd1,
      4'd0,  4'd2,  4'd4,  4'd6,  4'd8,  4'd10, 4'd12, 4'd14},
    '{4'd0,  4'd2,  4'd4,  4'd6,  4'd8,  4'd10, 4'd12, 4'd14,
      4'd15, 4'd13, 4'd11, 4'd9,  4'd7,  4'd5,  4'd3,  4'd1},
    '{4'd14, 4'd12, 4'd10, 4'd8,  4'd6,  4'd4,  4'd2,  4'd0,
      4'd1,  4'd3,  4'd5,  4'd7,  4'd9,  4'd11, 4'd13, 4'd15},
    '{4'd0,  4'd15, 4'd1,  4'd14, 4'd2,  4'd13, 4'd3,  4'd12,
      4'd4,  4'd11, 4'd5,  4'd10, 4'd6,  4'd9,  4'd7,  4'd8},
    '{4'd4,  4'd11, 4'd5,  4'd10, 4'd6,  4'd9,  4'd7,  4'd8,
      4'd0,  4'd15, 4'd1,  4'd14, 4'd2,  4'd13, 4'd3,  4'd12},
    '{4'd11, 4'd14, 4'd13, 4'd12, 4'd10, 4'd15, 4'd1,  4'd2,
      4'd4,  4'd6,  4'd8,  4'd0,  4'd9,  4'd7,  4'd5,  4'd3}
  };

  // Nibble j of the word sits in byte j/2; byte k uses rows 6-2k (low) and 7-2k (high).
  function automatic logic [WORD_W-1:0] substitute(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] s;
    int unsigned       row;
    s = '0;
    for (int unsigned j = 0; j < 8; j++) begin
      row = (6 - 2 * (j >> 1)) + (j & 1);
      s[4*j +: 4] = SBOX[row][v[4*j +: 4]];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

/* design/gbc_in_if.sv */
// Interface: input block channel (mode and two halves).
`default_nettype none
interface gbc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] left_in;
  logic [31:0] right_in;

  modport source (output valid, output func, output left_in, output right_in, input ready);
  modport sink   (input valid, input func, input left_in, input right_in, output ready);
endinterface
`default_nettype wire

/* design/gbc_out_if.sv */
// Interface: output block channel (two result halves).
`default_nettype none
interface gbc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_out;
  logic [31:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

/* design/gbc_round.sv */
// One Feistel round: key add, nibble substitution, rotate, XOR and half exchange.
`default_nettype none
module gbc_round (
  input  gbc_pkg::stage_t           stage_i,
  input  logic [gbc_pkg::WORD_W-1:0] key_i,
  output gbc_pkg::stage_t           stage_o
);
  import gbc_pkg::*;

  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] sub;
  logic [WORD_W-1:0] rot;

  always_comb begin
    sum = stage_i.right + key_i;
    sub = substitute(sum);
    rot = {sub[WORD_W-ROT_BITS-1:0], sub[WORD_W-1:WORD_W-ROT_BITS]};
    stage_o.func  = stage_i.func;
    stage_o.left  = stage_i.right;
    stage_o.right = stage_i.left ^ rot;
  end

endmodule
`default_nettype wire

/* design/gost_block_cipher_ecb_top.sv */
// GOST 28147-89 style ECB block cipher: eight key words and a rounds-deep round pipeline.
// Usage:
//   Write key words 0..7 through cfg_we_i / cfg_idx_i / cfg_data_i while the
//   pipeline is empty; each write lands at the clock edge where cfg_we_i is high.
//   Present blocks on in_ch (func 0 encrypt, 1 decrypt, left_in/right_in halves);
//   a block transfers when valid and ready are both high.
//   Results leave on out_ch as left_out/right_out, one per input block, in order.
// Pipeline: a block passes from stage 0 through stage ROUNDS - 1 in order, and
//   out_ch.valid rises once it is held in the last stage (one register stage per
//   Feistel round, each stage holding one add, substitution and XOR).
// Throughput: one block per cycle unless out_ch.ready is low; set by the round pipeline.
// Reset: all stage valid bits clear and all key words return to zero.
// Stall: when out_ch.ready is low the last stage holds its result; each stage
//   keeps filling while it or a stage ahead of it is empty, so input transfers
//   continue until every stage holds a block, and nothing is dropped or repeated.
`default_nettype none
module gost_block_cipher_ecb_top #(
  parameter int unsigned ROUNDS = gbc_pkg::ROUNDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gbc_pkg::KEY_IDX_W-1:0] cfg_idx_i,
  input  logic [gbc_pkg::WORD_W-1:0]    cfg_data_i,
  gbc_in_if.sink                        in_ch,
  gbc_out_if.source                     out_ch
);
  import gbc_pkg::*;

  logic [WORD_W-1:0] key_q [KEY_WORDS];

  stage_t            stage_q [ROUNDS];
  stage_t            round_in [ROUNDS];
  stage_t            round_out [ROUNDS];
  logic [WORD_W-1:0] round_key [ROUNDS];
  logic [ROUNDS-1:0] vld_q;
  logic [ROUNDS-1:0] vld_d;
  logic [ROUNDS-1:0] rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_WORDS; i++) key_q[i] <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    round_in[0].func  = in_ch.func;
    round_in[0].left  = in_ch.left_in;
    round_in[0].right = in_ch.right_in;
    for (int r = 1; r < ROUNDS; r++) round_in[r] = stage_q[r-1];
  end

  // Ready ripples back: a stage takes new data when empty or when it drains.
  always_comb begin
    rdy[ROUNDS-1] = !vld_q[ROUNDS-1] || out_ch.ready;
    for (int r = ROUNDS - 2; r >= 0; r--) rdy[r] = !vld_q[r] || rdy[r+1];
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = in_ch.valid;
    end
    for (int r = 1; r < ROUNDS; r++) begin
      if (rdy[r]) begin
        vld_d[r] = vld_q[r-1];
      end
    end
  end

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam int unsigned ENC_IDX = (r < ROUNDS - 8) ? (r % 8) : (7 - (r % 8));
    localparam int unsigned DEC_IDX = (r < 8) ? r : (7 - (r % 8));
    localparam logic [KEY_IDX_W-1:0] ENC_SEL = KEY_IDX_W'(ENC_IDX);
    localparam logic [KEY_IDX_W-1:0] DEC_SEL = KEY_IDX_W'(DEC_IDX);

    assign round_key[r] = (round_in[r].func == FUNC_DECRYPT) ? key_q[DEC_SEL]
                                                             : key_q[ENC_SEL];

    gbc_round u_round (
      .stage_i (round_in[r]),
      .key_i   (round_key[r]),
      .stage_o (round_out[r])
    );

    always_ff @(posedge clk_i) begin
      if (rdy[r]) begin
        stage_q[r] <= round_out[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ch.ready      = rdy[0];
  assign out_ch.valid     = vld_q[ROUNDS-1];
  // Undo the exchange of the last round.
  assign out_ch.left_out  = stage_q[ROUNDS-1].right;
  assign out_ch.right_out = stage_q[ROUNDS-1].left;

endmodule
`default_nettype wire
